>>> rtl/core/assert_macros.svh
// assertion macros for the cfar rtl, used by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define CFAR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CFAR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cacfar_pkg.sv
// package for the cell-averaging cfar detector: constants, state, command and status types
package cacfar_pkg;

	localparam int MAX_TRAIN = 16;
	localparam int MAX_GUARD = 8;
	localparam int DL_DEPTH  = 2 * (MAX_TRAIN + MAX_GUARD) + 1;
	localparam int DL_AW     = 6;
	localparam int TBL_DEPTH = 2 * MAX_TRAIN + 1;
	localparam logic [12:0] SEEN_CAP = 13'd4145;

	localparam logic       OP_TABLE  = 1'b0;
	localparam logic       OP_SAMPLE = 1'b1;
	localparam logic [4:0] REG_TRAIN = 5'd0;
	localparam logic [4:0] REG_GUARD = 5'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VAL,
		ST_ACC,
		ST_DRAIN,
		ST_TAB,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic       push;
		logic       tbl_wr;
		logic       rd_val;
		logic       rd_win;
		logic       rd_tab;
		logic       mul1;
		logic       mul2;
		logic       emit;
		logic       final_cell;
		logic [4:0] k;
		logic [4:0] i;
		logic [4:0] tr;
		logic [3:0] gd;
	} dp_cmd_t;

	typedef struct packed {
		logic [12:0] seen;
		logic        out_free;
	} dp_status_t;

endpackage

>>> rtl/core/ca_cfar_ifs.sv
// request and result channel interfaces of the cfar detector
interface ca_cfar_feed_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] sample_value;
	logic        last_sample;
	logic [5:0]  table_index;
	logic [31:0] table_value;

	modport source (output valid, op, sample_value, last_sample, table_index, table_value,
		input ready);
	modport sink (input valid, op, sample_value, last_sample, table_index, table_value,
		output ready);
endinterface

interface ca_cfar_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] cell_index;
	logic [15:0] cell_value;
	logic [20:0] window_sum;
	logic [5:0]  used_cells;
	logic        detected;
	logic        last_result;

	modport source (output valid, cell_index, cell_value, window_sum, used_cells, detected,
		last_result, input ready);
	modport sink (input valid, cell_index, cell_value, window_sum, used_cells, detected,
		last_result, output ready);
endinterface

>>> rtl/core/cacfar_ctrl.sv
// cfar sequencer: config registers, cell and window counters, state machine
module cacfar_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_index,
	input  logic [4:0]             cfg_data,
	input  logic                   req_valid,
	input  logic                   req_op,
	input  logic                   req_last,
	output logic                   req_ready,
	input  cacfar_pkg::dp_status_t status,
	output cacfar_pkg::dp_cmd_t    cmd
);
	import cacfar_pkg::*;
	`include "assert_macros.svh"

	ctl_state_t state_q, state_d;
	logic [4:0] train_q;
	logic [3:0] guard_q;
	logic [4:0] tr, k_q, i_q;
	logic [3:0] gd;
	logic [4:0] d;
	logic       last_q;
	logic       accept;
	logic       more;

	assign tr = (train_q > 5'(MAX_TRAIN)) ? 5'(MAX_TRAIN) : train_q;
	assign gd = (guard_q > 4'(MAX_GUARD)) ? 4'(MAX_GUARD) : guard_q;
	assign d  = tr + {1'b0, gd};
	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign more = last_q && (k_q != 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_q <= 5'd8;
			guard_q <= 4'd2;
		end else if (cfg_we) begin
			if (cfg_index == REG_TRAIN) train_q <= cfg_data;
			if (cfg_index == REG_GUARD) guard_q <= cfg_data[3:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_op == OP_SAMPLE &&
					(req_last || status.seen >= {8'b0, d})) state_d = ST_VAL;
			end
			ST_VAL:   state_d = (tr == 5'd0) ? ST_DRAIN : ST_ACC;
			ST_ACC:   state_d = (i_q == tr) ? ST_DRAIN : ST_ACC;
			ST_DRAIN: state_d = ST_TAB;
			ST_TAB:   state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) state_d = more ? ST_VAL : ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= 5'd0;
			i_q     <= 5'd0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req_op == OP_SAMPLE) begin
				last_q <= req_last;
				if (req_last && status.seen < {8'b0, d}) k_q <= status.seen[4:0];
				else k_q <= d;
			end
			if (state_q == ST_VAL) i_q <= 5'd1;
			else if (state_q == ST_ACC && i_q != tr) i_q <= i_q + 5'd1;
			if (state_q == ST_EMIT && status.out_free && more) k_q <= k_q - 5'd1;
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.push       = accept && req_op == OP_SAMPLE;
		cmd.tbl_wr     = accept && req_op == OP_TABLE;
		cmd.rd_val     = (state_q == ST_VAL);
		cmd.rd_win     = (state_q == ST_ACC);
		cmd.rd_tab     = (state_q == ST_TAB);
		cmd.mul1       = (state_q == ST_MUL1);
		cmd.mul2       = (state_q == ST_MUL2);
		cmd.emit       = (state_q == ST_EMIT) && status.out_free;
		cmd.final_cell = last_q && (k_q == 5'd0);
		cmd.k          = k_q;
		cmd.i          = i_q;
		cmd.tr         = tr;
		cmd.gd         = gd;
	end

	`CFAR_ASSERT(a_emit_free, cmd.emit |-> status.out_free, "result emitted into a full register")
	`CFAR_ASSERT(a_k_range, (state_q != ST_IDLE) |-> (k_q <= d), "tested cell beyond window")
	`CFAR_ASSERT(a_final_idle, (cmd.emit && cmd.final_cell) |=> (state_q == ST_IDLE), "flush did not end")
	`CFAR_ASSERT(a_win_count, (state_q == ST_ACC) |-> (i_q >= 5'd1 && i_q <= tr), "window index out of range")

endmodule

>>> rtl/core/cacfar_dp.sv
// cfar datapath: sample ring, multiplier table, window accumulation, threshold test, result register
module cacfar_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cacfar_pkg::dp_cmd_t    cmd,
	output cacfar_pkg::dp_status_t status,
	input  logic [15:0]            sample_value,
	input  logic [5:0]             table_index,
	input  logic [31:0]            table_value,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [11:0]            cell_index,
	output logic [15:0]            cell_value,
	output logic [20:0]            window_sum,
	output logic [5:0]             used_cells,
	output logic                   detected,
	output logic                   last_result
);
	import cacfar_pkg::*;

	logic [15:0] ring [2**DL_AW];
	logic [31:0] mult_tbl [TBL_DEPTH];

	logic [DL_AW-1:0] wp_q, addr_a, addr_b;
	logic [12:0] seen_q, n_q;
	logic [15:0] rd_a_q, rd_b_q, value_q;
	logic        val_s1, lv_s1, rv_s1;
	logic [20:0] sum_q;
	logic [5:0]  cnt_q;
	logic [31:0] alpha_q;
	logic [36:0] plo_q, phi_q;
	logic [21:0] vc_q;
	logic [5:0]  off, rgap;
	logic        lvalid, rvalid;
	logic [53:0] lhs, rhs;
	logic        target;
	logic        ovalid_q;
	logic [11:0] cidx_q;

	assign off    = {1'b0, cmd.k} + {2'b0, cmd.gd} + {1'b0, cmd.i};
	assign rgap   = {2'b0, cmd.gd} + {1'b0, cmd.i};
	assign lvalid = ({7'b0, off} <= n_q) && (off < 6'(DL_DEPTH));
	assign rvalid = ({1'b0, cmd.k} >= rgap);
	assign addr_a = cmd.rd_val ? (wp_q - DL_AW'(cmd.k)) : (wp_q - off);
	assign addr_b = wp_q - ({1'b0, cmd.k} - rgap);

	always_ff @(posedge clk) begin
		if (cmd.push) ring[wp_q + DL_AW'(1)] <= sample_value;
		rd_a_q <= ring[addr_a];
		rd_b_q <= ring[addr_b];
		if (cmd.tbl_wr && table_index < 6'(TBL_DEPTH)) mult_tbl[table_index] <= table_value;
		if (cmd.rd_tab) alpha_q <= mult_tbl[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			seen_q <= '0;
			n_q    <= '0;
		end else if (cmd.push) begin
			wp_q   <= wp_q + DL_AW'(1);
			n_q    <= seen_q;
			seen_q <= (seen_q < SEEN_CAP) ? seen_q + 13'd1 : seen_q;
		end else if (cmd.emit && cmd.final_cell) begin
			seen_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			lv_s1  <= 1'b0;
			rv_s1  <= 1'b0;
		end else begin
			val_s1 <= cmd.rd_val;
			lv_s1  <= cmd.rd_win && lvalid;
			rv_s1  <= cmd.rd_win && rvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_val) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			sum_q <= sum_q + (lv_s1 ? {5'b0, rd_a_q} : 21'd0) + (rv_s1 ? {5'b0, rd_b_q} : 21'd0);
			cnt_q <= cnt_q + {5'b0, lv_s1} + {5'b0, rv_s1};
		end
		if (val_s1) value_q <= rd_a_q;
		if (cmd.mul1) begin
			plo_q <= sum_q * alpha_q[15:0];
			vc_q  <= value_q * cnt_q;
		end
		if (cmd.mul2) phi_q <= sum_q * alpha_q[31:16];
	end

	assign lhs    = {16'b0, vc_q, 16'b0};
	assign rhs    = {1'b0, phi_q, 16'b0} + {17'b0, plo_q};
	assign target = (cnt_q == 6'd0) ? (value_q != 16'd0) : (lhs > rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			cidx_q   <= '0;
		end else begin
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
				cidx_q   <= cmd.final_cell ? 12'd0 : cidx_q + 12'd1;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cell_index  <= cidx_q;
			cell_value  <= value_q;
			window_sum  <= sum_q;
			used_cells  <= cnt_q;
			detected    <= target;
			last_result <= cmd.final_cell;
		end
	end

	assign res_valid       = ovalid_q;
	assign status.out_free = !ovalid_q || res_ready;
	assign status.seen     = seen_q;

endmodule

>>> rtl/core/ca_cfar_detector_top.sv
// top level of the cell-averaging cfar detector
// Each sample request tests zero or one cell, or on the last sample of a profile every
// remaining cell, oldest first. Each tested cell needs one pair of reads per training
// distance (train_cells, capped at 16) from the two-port sample ring plus the value read,
// the table read and the two-step split threshold multiply, and it waits while the output
// register still holds an unaccepted result. The block takes no request until the last of
// its results is in the output register. A table write leaves the block ready for the next
// request. The output register lets a result wait while the next cell is worked on.
module ca_cfar_detector_top (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_index,
	input  logic [4:0] cfg_data,
	ca_cfar_feed_if.sink     feed,
	ca_cfar_result_if.source result
);
	import cacfar_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	cacfar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (feed.valid),
		.req_op    (feed.op),
		.req_last  (feed.last_sample),
		.req_ready (feed.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cacfar_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_value (feed.sample_value),
		.table_index  (feed.table_index),
		.table_value  (feed.table_value),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.cell_index   (result.cell_index),
		.cell_value   (result.cell_value),
		.window_sum   (result.window_sum),
		.used_cells   (result.used_cells),
		.detected     (result.detected),
		.last_result  (result.last_result)
	);

endmodule

>>> sim/tb_ca_cfar_detector_top.sv
// testbench for the cell-averaging cfar detector: predicts every cell result and checks it
`timescale 1ns / 1ps

module tb_ca_cfar_detector_top;
	import cacfar_pkg::*;

	localparam int PROFILE_LEN = 4096;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 60;
	localparam int unsigned PER_WINDOW = 39;

	typedef struct {
		logic [11:0] cell_index;
		logic [15:0] cell_value;
		logic [20:0] window_sum;
		logic [5:0]  used_cells;
		logic        detected;
		logic        last_result;
	} cell_result_t;

	class cfar_scoreboard;
		cell_result_t pending[$];
		logic [15:0]  ring[DL_DEPTH];
		logic [31:0]  alpha_tbl[TBL_DEPTH];
		int unsigned  seen;
		int unsigned  cell_no;
		int unsigned  train_reg;
		int unsigned  guard_reg;
		int           errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			foreach (alpha_tbl[i]) alpha_tbl[i] = '0;
			seen = 0;
			cell_no = 0;
			train_reg = 8;
			guard_reg = 2;
			errors = 0;
		endfunction

		function void set_cfg(int unsigned tr, int unsigned gd);
			train_reg = tr;
			guard_reg = gd;
		endfunction

		function void test_cell(int unsigned k, int unsigned n, int unsigned tr,
				int unsigned gd, bit final_cell);
			cell_result_t r;
			int unsigned sum;
			int unsigned cnt;
			int unsigned off;
			longint unsigned lhs;
			longint unsigned rhs;
			sum = 0;
			cnt = 0;
			for (int unsigned i = 1; i <= tr; i++) begin
				off = k + gd + i;
				if (off <= n && off < DL_DEPTH) begin
					sum += ring[off];
					cnt++;
				end
				if (k >= gd + i) begin
					sum += ring[k - gd - i];
					cnt++;
				end
			end
			r.cell_index  = cell_no[11:0];
			r.cell_value  = ring[k];
			r.window_sum  = sum[20:0];
			r.used_cells  = cnt[5:0];
			r.last_result = final_cell;
			if (cnt == 0) begin
				r.detected = ring[k] != 0;
			end else begin
				lhs = longint'(ring[k]) * cnt * 65536;
				rhs = longint'(sum) * alpha_tbl[cnt];
				r.detected = lhs > rhs;
			end
			pending.push_back(r);
			cell_no = (cell_no + 1) % PROFILE_LEN;
		endfunction

		function void note_input(logic op, logic [15:0] v, logic last, logic [5:0] ti,
				logic [31:0] tv);
			int unsigned tr;
			int unsigned gd;
			int unsigned d;
			int unsigned n;
			int unsigned k;
			if (op == OP_TABLE) begin
				if (ti < TBL_DEPTH) alpha_tbl[ti] = tv;
				return;
			end
			tr = train_reg > MAX_TRAIN ? MAX_TRAIN : train_reg;
			gd = guard_reg > MAX_GUARD ? MAX_GUARD : guard_reg;
			d = tr + gd;
			for (int i = DL_DEPTH - 1; i > 0; i--) ring[i] = ring[i - 1];
			ring[0] = v;
			n = seen;
			if (seen < SEEN_CAP) seen++;
			if (!last) begin
				if (n >= d) test_cell(d, n, tr, gd, 1'b0);
			end else begin
				k = n < d ? n : d;
				forever begin
					test_cell(k, n, tr, gd, k == 0);
					if (k == 0) break;
					k--;
				end
				seen = 0;
				cell_no = 0;
			end
		endfunction

		function void check(cell_result_t got);
			cell_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result cell %0d", $time, got.cell_index);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.cell_index !== exp_r.cell_index) begin
				$display("%0t: cell_index exp %0d got %0d", $time, exp_r.cell_index,
					got.cell_index);
				errors++;
			end
			if (got.cell_value !== exp_r.cell_value) begin
				$display("%0t: cell_value exp %0d got %0d", $time, exp_r.cell_value,
					got.cell_value);
				errors++;
			end
			if (got.window_sum !== exp_r.window_sum) begin
				$display("%0t: window_sum exp %0d got %0d", $time, exp_r.window_sum,
					got.window_sum);
				errors++;
			end
			if (got.used_cells !== exp_r.used_cells) begin
				$display("%0t: used_cells exp %0d got %0d", $time, exp_r.used_cells,
					got.used_cells);
				errors++;
			end
			if (got.detected !== exp_r.detected) begin
				$display("%0t: detected exp %0d got %0d", $time, exp_r.detected,
					got.detected);
				errors++;
			end
			if (got.last_result !== exp_r.last_result) begin
				$display("%0t: last_result exp %0d got %0d", $time, exp_r.last_result,
					got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_index;
	logic [4:0] cfg_data;

	ca_cfar_feed_if   feed();
	ca_cfar_result_if res_if();

	ca_cfar_detector_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.feed     (feed.sink),
		.result   (res_if.source)
	);

	cfar_scoreboard detections = new();
	int unsigned    burst_left = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    stall_mode = 0;
	int unsigned    stall_phase = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		feed.valid = 1'b0;
		feed.op = OP_SAMPLE;
		feed.sample_value = '0;
		feed.last_sample = 1'b0;
		feed.table_index = '0;
		feed.table_value = '0;
		res_if.ready = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall pattern, reselected whenever stall_phase[5:0] is zero
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[5:0] == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= 1'($urandom_range(0, 1));
			2: res_if.ready <= stall_phase[3:0] > 10;
			default: res_if.ready <= $urandom_range(0, 7) != 0;
		endcase
	end

	always @(posedge clk) begin
		cell_result_t got;
		if (res_if.valid && res_if.ready) begin
			got.cell_index  = res_if.cell_index;
			got.cell_value  = res_if.cell_value;
			got.window_sum  = res_if.window_sum;
			got.used_cells  = res_if.used_cells;
			got.detected    = res_if.detected;
			got.last_result = res_if.last_result;
			detections.check(got);
		end
	end

	always @(posedge clk) begin
		if ((feed.valid && feed.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_ca_cfar_detector_top NOT OK");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [15:0] v, logic last, logic [5:0] ti,
			logic [31:0] tv);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				feed.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		feed.valid <= 1'b1;
		feed.op <= op;
		feed.sample_value <= v;
		feed.last_sample <= last;
		feed.table_index <= ti;
		feed.table_value <= tv;
		do @(posedge clk); while (!feed.ready);
		detections.note_input(op, v, last, ti, tv);
	endtask

	task automatic drain_and_settle();
		feed.valid <= 1'b0;
		burst_left = 0;
		while (detections.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_window(logic [4:0] tr, logic [4:0] gd);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TRAIN;
		cfg_data <= tr;
		@(posedge clk);
		cfg_index <= REG_GUARD;
		cfg_data <= gd;
		@(posedge clk);
		cfg_we <= 1'b0;
		detections.set_cfg(tr, gd[3:0]);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [31:0] pick_alpha();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(32'h0001_0000, 32'h000A_0000);
		endcase
	endfunction

	task automatic send_profile(int unsigned len);
		for (int unsigned i = 1; i <= len; i++)
			send_request(OP_SAMPLE, pick_sample(), i == len, 6'($urandom_range(0, 63)),
				$urandom);
	endtask

	initial begin
		logic [4:0] tr_set[8] = '{5'd8, 5'd1, 5'd16, 5'd31, 5'd0, 5'd0, 5'd3, 5'd12};
		logic [4:0] gd_set[8] = '{5'd2, 5'd0, 5'd8, 5'd15, 5'd0, 5'd5, 5'd1, 5'd4};
		int unsigned sent;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole multiplier table first
		for (int i = 0; i < TBL_DEPTH; i++)
			send_request(OP_TABLE, 16'($urandom), 1'b0, i[5:0], pick_alpha());
		send_request(OP_TABLE, 16'hFFFF, 1'b1, 6'd33, 32'hFFFF_FFFF);
		send_request(OP_TABLE, 16'h0, 1'b0, 6'd63, 32'h0);
		send_request(OP_SAMPLE, 16'hFFFF, 1'b1, 6'd0, 32'h0);
		send_request(OP_SAMPLE, 16'h0000, 1'b0, 6'd0, 32'h0);
		send_request(OP_SAMPLE, 16'h0000, 1'b1, 6'd0, 32'h0);
		send_profile(5);
		send_profile(14);

		foreach (tr_set[p]) begin
			set_window(tr_set[p], gd_set[p]);
			sent = 0;
			while (sent < PER_WINDOW) begin
				if ($urandom_range(0, 5) == 0) begin
					send_request(OP_TABLE, 16'($urandom), 1'($urandom_range(0, 1)),
						6'($urandom_range(0, 63)), pick_alpha());
					sent++;
				end else begin
					automatic int unsigned len = $urandom_range(0, 3) == 0 ?
						$urandom_range(1, 6) : $urandom_range(8, 30);
					if (len > PER_WINDOW - sent) len = PER_WINDOW - sent;
					send_profile(len);
					sent += len;
				end
			end
		end

		drain_and_settle();
		if (detections.errors == 0)
			$display("tb_ca_cfar_detector_top OK");
		else
			$display("tb_ca_cfar_detector_top NOT OK");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cacfar_pkg.sv
rtl/core/ca_cfar_ifs.sv
rtl/core/cacfar_ctrl.sv
rtl/core/cacfar_dp.sv
rtl/core/ca_cfar_detector_top.sv
sim/tb_ca_cfar_detector_top.sv
